// ----- rtl/nfts_pkg.sv -----
package nfts_pkg;

   // request kinds carried in req_tuser
   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_QUERY  = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;

   // result status codes carried in rsp_tuser
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NO_CAND   = 2'd2;
   localparam logic [1:0] STATUS_NOT_VALID = 2'd3;

   // control that travels alongside each slot in the distance pipeline
   typedef struct packed {
      logic valid;
      logic cand;
      logic last;
   } nfts_tag_type;

endpackage

// ----- rtl/nearest_free_target_search.sv -----
// Nearest free target search
//
// Request channel (req_*): one transfer per command. req_tuser selects the
// command (add point, nearest query and claim, remove slot); req_tdata holds
// the coordinates and the slot to remove. Result channel (rsp_*): exactly one
// transfer per command, in command order.
//
// The point table lives in one single-port-read, single-port-write memory of
// TABLE_DEPTH words. An add scans the table one slot a cycle for the lowest
// free slot. A query streams every slot through the distance and root
// pipeline, one slot a cycle, then writes the claim. A remove reads and
// writes back one slot. One command is worked on at a time; the memory scan
// sets the rate.
//
// After reset the block clears every slot of the table and holds req_tready
// low meanwhile. A finished result waits in the output register while the
// next command is already accepted and processed; a further result waits in
// the block until rsp_tready takes the previous one.
module nearest_free_target_search #(
   parameter  int TABLE_DEPTH = 64,
   parameter  int COORD_BITS  = 8,
   localparam int REQ_W       = ((2 * COORD_BITS + 6 + 7) / 8) * 8,
   localparam int RSP_W       = ((2 * COORD_BITS + 15 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // pos_x, pos_y, target_entry
   input  logic [1:0]       req_tuser,   // action
   // result channel
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // entry_out, hit_x, hit_y, root_distance
   output logic [2:0]       rsp_tuser    // found, status
);

   import nfts_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int WW = 2 * CB + 2;
   localparam int RW = CB + 1;
   localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

   // sequencer states
   localparam logic [3:0] ST_CLEAR     = 4'd0;
   localparam logic [3:0] ST_IDLE      = 4'd1;
   localparam logic [3:0] ST_ADD_SCAN  = 4'd2;
   localparam logic [3:0] ST_ADD_WAIT  = 4'd3;
   localparam logic [3:0] ST_QRY_SCAN  = 4'd4;
   localparam logic [3:0] ST_QRY_WAIT  = 4'd5;
   localparam logic [3:0] ST_QRY_CLAIM = 4'd6;
   localparam logic [3:0] ST_REM_CHECK = 4'd7;
   localparam logic [3:0] ST_POST      = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [AW-1:0]     scan_ff, scan_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [AW-1:0]     rd_addr_ff, rd_addr_in;
   logic [CB-1:0]     px_ff, px_in, py_ff, py_in;
   logic [5:0]        te_ff, te_in;
   logic              have_ff, have_in;
   logic [AW-1:0]     best_slot_ff, best_slot_in;
   logic [CB-1:0]     best_x_ff, best_x_in, best_y_ff, best_y_in;
   logic [RW-1:0]     best_root_ff, best_root_in;
   logic              res_found_ff, res_found_in;
   logic [5:0]        res_entry_ff, res_entry_in;
   logic [CB-1:0]     res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic [8:0]        res_root_ff, res_root_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_tdata_ff, rsp_tdata_in;
   logic [2:0]        rsp_tuser_ff, rsp_tuser_in;

   // request fields
   logic [1:0]        req_action;
   logic [CB-1:0]     req_x, req_y;
   logic [5:0]        req_te;
   logic [31:0]       req_te_wide;
   logic              req_te_ok;

   // table port
   logic              tbl_we, tbl_re;
   logic [AW-1:0]     tbl_waddr, tbl_raddr;
   logic [WW-1:0]     tbl_wdata, tbl_rdata;
   logic [CB-1:0]     rd_x, rd_y;
   logic              rd_valid, rd_claimed;

   // distance pipeline
   nfts_tag_type      dist_in_tag, dist_out_tag;
   logic [AW-1:0]     dist_out_slot;
   logic [CB-1:0]     dist_out_x, dist_out_y;
   logic [RW-1:0]     dist_out_root;

   // narrowing helpers
   logic [31:0]       rd_addr_wide, best_slot_wide;
   logic [RW+8:0]     best_root_wide;

   // request unpacking
   always_comb begin
      req_action  = req_tuser;
      req_x       = req_tdata[CB-1:0];
      req_y       = req_tdata[2*CB-1:CB];
      req_te      = req_tdata[2*CB+5:2*CB];
      req_te_wide = 32'(req_te);
      req_te_ok   = req_te_wide < TABLE_DEPTH;
   end

   assign req_tready = (state_ff == ST_IDLE);

   // table word fields, lowest bits first: x, y, claimed, valid
   always_comb begin
      rd_x       = tbl_rdata[CB-1:0];
      rd_y       = tbl_rdata[2*CB-1:CB];
      rd_claimed = tbl_rdata[2*CB];
      rd_valid   = tbl_rdata[2*CB+1];
   end

   nfts_table #(
      .DEPTH     (TABLE_DEPTH),
      .ADDR_BITS (AW),
      .WORD_BITS (WW)
   ) u_table (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (tbl_wdata),
      .re    (tbl_re),
      .raddr (tbl_raddr),
      .rdata (tbl_rdata)
   );

   // slots read during a query go through the distance pipeline
   always_comb begin
      dist_in_tag.valid = rd_pend_ff &&
                          (state_ff == ST_QRY_SCAN || state_ff == ST_QRY_WAIT);
      dist_in_tag.cand  = rd_valid && !rd_claimed;
      dist_in_tag.last  = (rd_addr_ff == LAST_SLOT);
   end

   nfts_dist #(
      .SLOT_BITS  (AW),
      .COORD_BITS (CB)
   ) u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_tag   (dist_in_tag),
      .in_slot  (rd_addr_ff),
      .in_px    (px_ff),
      .in_py    (py_ff),
      .in_x     (rd_x),
      .in_y     (rd_y),
      .out_tag  (dist_out_tag),
      .out_slot (dist_out_slot),
      .out_x    (dist_out_x),
      .out_y    (dist_out_y),
      .out_root (dist_out_root)
   );

   always_comb begin
      rd_addr_wide   = 32'(rd_addr_ff);
      best_slot_wide = 32'(best_slot_ff);
      best_root_wide = (RW+9)'(best_root_ff);
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      rd_pend_in    = 1'b0;
      rd_addr_in    = scan_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      te_in         = te_ff;
      have_in       = have_ff;
      best_slot_in  = best_slot_ff;
      best_x_in     = best_x_ff;
      best_y_in     = best_y_ff;
      best_root_in  = best_root_ff;
      res_found_in  = res_found_ff;
      res_entry_in  = res_entry_ff;
      res_x_in      = res_x_ff;
      res_y_in      = res_y_ff;
      res_root_in   = res_root_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      tbl_we        = 1'b0;
      tbl_waddr     = scan_ff;
      tbl_wdata     = '0;
      tbl_re        = 1'b0;
      tbl_raddr     = scan_ff;

      unique case (state_ff)
         // clearing pass after reset
         ST_CLEAR: begin
            tbl_we    = 1'b1;
            tbl_waddr = scan_ff;
            tbl_wdata = '0;
            scan_in   = scan_ff + 1'b1;
            if (scan_ff == LAST_SLOT) begin
               scan_in  = '0;
               state_in = ST_IDLE;
            end
         end

         // take a command
         ST_IDLE: begin
            if (req_tvalid) begin
               px_in   = req_x;
               py_in   = req_y;
               te_in   = req_te;
               scan_in = '0;
               have_in = 1'b0;
               unique case (req_action)
                  ACT_ADD:   state_in = ST_ADD_SCAN;
                  ACT_QUERY: state_in = ST_QRY_SCAN;
                  ACT_REMOVE: begin
                     res_found_in = 1'b0;
                     res_entry_in = req_te;
                     res_x_in     = '0;
                     res_y_in     = '0;
                     res_root_in  = '0;
                     if (req_te_ok) begin
                        tbl_re    = 1'b1;
                        tbl_raddr = req_te_wide[AW-1:0];
                        state_in  = ST_REM_CHECK;
                     end else begin
                        res_status_in = STATUS_NOT_VALID;
                        state_in      = ST_POST;
                     end
                  end
                  default: begin
                     res_found_in  = 1'b0;
                     res_entry_in  = '0;
                     res_x_in      = '0;
                     res_y_in      = '0;
                     res_root_in   = '0;
                     res_status_in = STATUS_OK;
                     state_in      = ST_POST;
                  end
               endcase
            end
         end

         // lowest free slot search
         ST_ADD_SCAN, ST_ADD_WAIT: begin
            if (state_ff == ST_ADD_SCAN) begin
               tbl_re     = 1'b1;
               tbl_raddr  = scan_ff;
               rd_pend_in = 1'b1;
               rd_addr_in = scan_ff;
               scan_in    = scan_ff + 1'b1;
               if (scan_ff == LAST_SLOT) begin
                  state_in = ST_ADD_WAIT;
               end
            end
            res_found_in = 1'b0;
            res_x_in     = '0;
            res_y_in     = '0;
            res_root_in  = '0;
            if (rd_pend_ff && !rd_valid) begin
               tbl_we        = 1'b1;
               tbl_waddr     = rd_addr_ff;
               tbl_wdata     = {1'b1, 1'b0, py_ff, px_ff};
               rd_pend_in    = 1'b0;
               res_entry_in  = rd_addr_wide[5:0];
               res_status_in = STATUS_OK;
               state_in      = ST_POST;
            end else if (rd_pend_ff && rd_addr_ff == LAST_SLOT) begin
               rd_pend_in    = 1'b0;
               res_entry_in  = '0;
               res_status_in = STATUS_FULL;
               state_in      = ST_POST;
            end
         end

         // stream every slot into the distance pipeline
         ST_QRY_SCAN, ST_QRY_WAIT: begin
            if (state_ff == ST_QRY_SCAN) begin
               tbl_re     = 1'b1;
               tbl_raddr  = scan_ff;
               rd_pend_in = 1'b1;
               rd_addr_in = scan_ff;
               scan_in    = scan_ff + 1'b1;
               if (scan_ff == LAST_SLOT) begin
                  state_in = ST_QRY_WAIT;
               end
            end
            // strict less-than keeps the lowest slot on a tie
            if (dist_out_tag.valid && dist_out_tag.cand &&
                (!have_ff || dist_out_root < best_root_ff)) begin
               have_in      = 1'b1;
               best_slot_in = dist_out_slot;
               best_x_in    = dist_out_x;
               best_y_in    = dist_out_y;
               best_root_in = dist_out_root;
            end
            if (dist_out_tag.valid && dist_out_tag.last) begin
               state_in = ST_QRY_CLAIM;
            end
         end

         // claim the nearest slot
         ST_QRY_CLAIM: begin
            if (have_ff) begin
               tbl_we        = 1'b1;
               tbl_waddr     = best_slot_ff;
               tbl_wdata     = {1'b1, 1'b1, best_y_ff, best_x_ff};
               res_found_in  = 1'b1;
               res_entry_in  = best_slot_wide[5:0];
               res_x_in      = best_x_ff;
               res_y_in      = best_y_ff;
               res_root_in   = best_root_wide[8:0];
               res_status_in = STATUS_OK;
            end else begin
               res_found_in  = 1'b0;
               res_entry_in  = '0;
               res_x_in      = '0;
               res_y_in      = '0;
               res_root_in   = '0;
               res_status_in = STATUS_NO_CAND;
            end
            state_in = ST_POST;
         end

         // free the slot if it holds a point
         ST_REM_CHECK: begin
            if (rd_valid) begin
               tbl_we        = 1'b1;
               tbl_waddr     = 32'(te_ff) < TABLE_DEPTH ? AW'(te_ff) : '0;
               tbl_wdata     = {1'b0, 1'b0, rd_y, rd_x};
               res_status_in = STATUS_OK;
            end else begin
               res_status_in = STATUS_NOT_VALID;
            end
            state_in = ST_POST;
         end

         // hand the result to the output register
         ST_POST: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_tdata_in = RSP_W'({res_root_ff, res_y_ff, res_x_ff, res_entry_ff});
               rsp_tuser_in = {res_status_ff, res_found_ff};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         scan_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         rd_pend_ff   <= rd_pend_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_addr_ff    <= rd_addr_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      te_ff         <= te_in;
      best_slot_ff  <= best_slot_in;
      best_x_ff     <= best_x_in;
      best_y_ff     <= best_y_in;
      best_root_ff  <= best_root_in;
      res_found_ff  <= res_found_in;
      res_entry_ff  <= res_entry_in;
      res_x_ff      <= res_x_in;
      res_y_ff      <= res_y_in;
      res_root_ff   <= res_root_in;
      res_status_ff <= res_status_in;
      rsp_tdata_ff  <= rsp_tdata_in;
      rsp_tuser_ff  <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

`ifndef SYNTHESIS
   // reset always restarts the clearing pass
   a_reset_clears: assert property (@(posedge clock)
      reset |=> state_ff == ST_CLEAR)
      else $error("reset did not start the clearing pass");

   // the table is never written while waiting for a command
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !tbl_we)
      else $error("table written while idle");

   // a successful claim writes a valid, claimed word
   a_claim_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QRY_CLAIM && have_ff) |->
         (tbl_we && tbl_wdata[2*CB+1] && tbl_wdata[2*CB]))
      else $error("claim write malformed");

   // distance results only arrive during a query scan
   a_dist_in_query: assert property (@(posedge clock) disable iff (reset)
      dist_out_tag.valid |-> (state_ff == ST_QRY_SCAN || state_ff == ST_QRY_WAIT))
      else $error("distance result outside a query");

   // a result is only posted after the previous one is taken
   a_post_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POST && rsp_valid_ff && !rsp_tready) |=>
         (state_ff == ST_POST && $stable(rsp_tdata_ff)))
      else $error("result overran the output register");
`endif

endmodule

// ----- rtl/nfts_table.sv -----
module nfts_table #(
   parameter int DEPTH      = 64,
   parameter int ADDR_BITS  = 6,
   parameter int WORD_BITS  = 18
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WORD_BITS-1:0] wdata,
   input  logic                 re,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [WORD_BITS-1:0] rdata
);

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rdata_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/nfts_dist.sv -----
module nfts_dist #(
   parameter int SLOT_BITS  = 6,
   parameter int COORD_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  nfts_pkg::nfts_tag_type       in_tag,
   input  logic [SLOT_BITS-1:0]         in_slot,
   input  logic [COORD_BITS-1:0]        in_px,
   input  logic [COORD_BITS-1:0]        in_py,
   input  logic [COORD_BITS-1:0]        in_x,
   input  logic [COORD_BITS-1:0]        in_y,
   output nfts_pkg::nfts_tag_type       out_tag,
   output logic [SLOT_BITS-1:0]         out_slot,
   output logic [COORD_BITS-1:0]        out_x,
   output logic [COORD_BITS-1:0]        out_y,
   output logic [COORD_BITS:0]          out_root
);

   import nfts_pkg::*;

   localparam int RW  = COORD_BITS + 1;   // root width
   localparam int RDW = 2 * RW;           // padded radicand width
   localparam int RMW = RW + 3;           // remainder width
   localparam int SQW = 2 * COORD_BITS;   // square width

   // front stages: difference, squares, sum
   nfts_tag_type            a_tag_ff, b_tag_ff;
   logic [SLOT_BITS-1:0]    a_slot_ff, b_slot_ff;
   logic [COORD_BITS-1:0]   a_x_ff, a_y_ff, b_x_ff, b_y_ff;
   logic [COORD_BITS-1:0]   a_dx_ff, a_dy_ff;
   logic [SQW-1:0]          b_sx_ff, b_sy_ff;
   logic [COORD_BITS-1:0]   dx_in, dy_in;

   // root stages, index 0 holds the radicand
   nfts_tag_type            tag_ff  [RW+1];
   logic [SLOT_BITS-1:0]    slot_ff [RW+1];
   logic [COORD_BITS-1:0]   x_ff    [RW+1];
   logic [COORD_BITS-1:0]   y_ff    [RW+1];
   logic [RDW-1:0]          rad_ff  [RW+1];
   logic [RMW-1:0]          rem_ff  [RW+1];
   logic [RW-1:0]           root_ff [RW+1];

   // absolute differences
   always_comb begin
      dx_in = (in_px > in_x) ? (in_px - in_x) : (in_x - in_px);
      dy_in = (in_py > in_y) ? (in_py - in_y) : (in_y - in_py);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_tag_ff <= '0;
      end else begin
         a_tag_ff <= in_tag;
      end
      a_slot_ff <= in_slot;
      a_x_ff    <= in_x;
      a_y_ff    <= in_y;
      a_dx_ff   <= dx_in;
      a_dy_ff   <= dy_in;
   end

   // squares
   always_ff @(posedge clock) begin
      if (reset) begin
         b_tag_ff <= '0;
      end else begin
         b_tag_ff <= a_tag_ff;
      end
      b_slot_ff <= a_slot_ff;
      b_x_ff    <= a_x_ff;
      b_y_ff    <= a_y_ff;
      b_sx_ff   <= SQW'(a_dx_ff) * SQW'(a_dx_ff);
      b_sy_ff   <= SQW'(a_dy_ff) * SQW'(a_dy_ff);
   end

   // sum of squares into the root pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff[0] <= '0;
      end else begin
         tag_ff[0] <= b_tag_ff;
      end
      slot_ff[0] <= b_slot_ff;
      x_ff[0]    <= b_x_ff;
      y_ff[0]    <= b_y_ff;
      rad_ff[0]  <= RDW'(b_sx_ff) + RDW'(b_sy_ff);
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
   end

   // one root bit per stage, most significant first
   for (genvar k = 0; k < RW; k++) begin : g_root
      logic [RMW-1:0] shifted;
      logic [RMW-1:0] trial;

      always_comb begin
         shifted = {rem_ff[k][RMW-3:0], rad_ff[k][2*(RW-1-k)+1 -: 2]};
         trial   = RMW'({root_ff[k], 2'b01});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k+1] <= '0;
         end else begin
            tag_ff[k+1] <= tag_ff[k];
         end
         slot_ff[k+1] <= slot_ff[k];
         x_ff[k+1]    <= x_ff[k];
         y_ff[k+1]    <= y_ff[k];
         rad_ff[k+1]  <= rad_ff[k];
         if (shifted >= trial) begin
            rem_ff[k+1]  <= shifted - trial;
            root_ff[k+1] <= {root_ff[k][RW-2:0], 1'b1};
         end else begin
            rem_ff[k+1]  <= shifted;
            root_ff[k+1] <= {root_ff[k][RW-2:0], 1'b0};
         end
      end
   end

   assign out_tag  = tag_ff[RW];
   assign out_slot = slot_ff[RW];
   assign out_x    = x_ff[RW];
   assign out_y    = y_ff[RW];
   assign out_root = root_ff[RW];

endmodule
